@@ rtl/bba_pkg.sv @@
// Package for the bounding box accumulator: coordinate type, action and
// operation codes, axis codes, and the command and result beats.
// No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int COORD_W = 32;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W:0]   extent_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [2:0] ACT_CLEAR     = 3'd0;
    localparam logic [2:0] ACT_POINT     = 3'd1;
    localparam logic [2:0] ACT_BOX       = 3'd2;
    localparam logic [2:0] ACT_LOAD_LOW  = 3'd3;
    localparam logic [2:0] ACT_LOAD_HIGH = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_GROW,
        OP_LOAD_LOW,
        OP_LOAD_HIGH
    } op_t;

    typedef struct packed {
        op_t    op;
        logic   use_a;
        logic   use_b;
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t bx;
        coord_t by;
        coord_t bz;
    } cmd_t;

    typedef struct packed {
        coord_t     low_x;
        coord_t     low_y;
        coord_t     low_z;
        coord_t     high_x;
        coord_t     high_y;
        coord_t     high_z;
        logic [1:0] longest_axis;
    } result_t;

endpackage

@@ rtl/bba_front.sv @@
// Front end: accepts input beats, decodes the action into a command and
// holds commands in a two-entry queue. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           action,
    input  bba_pkg::coord_t      corner_a_x,
    input  bba_pkg::coord_t      corner_a_y,
    input  bba_pkg::coord_t      corner_a_z,
    input  bba_pkg::coord_t      corner_b_x,
    input  bba_pkg::coord_t      corner_b_y,
    input  bba_pkg::coord_t      corner_b_z,
    input  logic                 corner_a_finite,
    input  logic                 corner_b_finite,
    output logic                 cmd_valid,
    input  logic                 cmd_take,
    output bba_pkg::cmd_t        cmd
);

    bba_pkg::cmd_t q_mem [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    bba_pkg::cmd_t dec;
    logic          do_push, do_pop;

    always_comb
    begin
        dec.ax    = corner_a_x;
        dec.ay    = corner_a_y;
        dec.az    = corner_a_z;
        dec.bx    = corner_b_x;
        dec.by    = corner_b_y;
        dec.bz    = corner_b_z;
        dec.use_a = 1'b0;
        dec.use_b = 1'b0;
        case (action)
            bba_pkg::ACT_CLEAR:
            begin
                dec.op = bba_pkg::OP_CLEAR;
            end
            bba_pkg::ACT_POINT:
            begin
                dec.op    = bba_pkg::OP_GROW;
                dec.use_a = 1'b1;
            end
            bba_pkg::ACT_BOX:
            begin
                dec.op    = bba_pkg::OP_GROW;
                dec.use_a = corner_a_finite;
                dec.use_b = corner_b_finite;
            end
            bba_pkg::ACT_LOAD_LOW:
            begin
                dec.op = bba_pkg::OP_LOAD_LOW;
            end
            bba_pkg::ACT_LOAD_HIGH:
            begin
                dec.op = bba_pkg::OP_LOAD_HIGH;
            end
            default:
            begin
                dec.op = bba_pkg::OP_NOP;
            end
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

@@ rtl/bba_back.sv @@
// Back end: executes commands on the box registers, finds the longest
// axis and queues result beats in a two-entry queue. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_take,
    input  bba_pkg::cmd_t        cmd,
    output logic                 empty,
    input  logic                 pop,
    output bba_pkg::result_t     res
);

    bba_pkg::coord_t  low_reg  [3];
    bba_pkg::coord_t  high_reg [3];
    bba_pkg::coord_t  low_next  [3];
    bba_pkg::coord_t  high_next [3];
    bba_pkg::coord_t  pa [3];
    bba_pkg::coord_t  pb [3];
    bba_pkg::extent_t ext [3];
    logic [1:0]       axis;
    bba_pkg::result_t new_res;

    bba_pkg::result_t q_mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_pop;

    assign pa[0] = cmd.ax;
    assign pa[1] = cmd.ay;
    assign pa[2] = cmd.az;
    assign pb[0] = cmd.bx;
    assign pb[1] = cmd.by;
    assign pb[2] = cmd.bz;

    assign cmd_take = cmd_valid && (count_reg != 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_pop   = pop && !empty;
    assign res      = q_mem[rd_ptr_reg];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            low_next[i]  = low_reg[i];
            high_next[i] = high_reg[i];
            case (cmd.op)
                bba_pkg::OP_CLEAR:
                begin
                    low_next[i]  = bba_pkg::COORD_MAX;
                    high_next[i] = bba_pkg::COORD_MIN;
                end
                bba_pkg::OP_GROW:
                begin
                    if (cmd.use_a && (pa[i] < low_next[i]))
                        low_next[i] = pa[i];
                    if (cmd.use_b && (pb[i] < low_next[i]))
                        low_next[i] = pb[i];
                    if (cmd.use_a && (pa[i] > high_next[i]))
                        high_next[i] = pa[i];
                    if (cmd.use_b && (pb[i] > high_next[i]))
                        high_next[i] = pb[i];
                end
                bba_pkg::OP_LOAD_LOW:
                begin
                    low_next[i] = pa[i];
                end
                bba_pkg::OP_LOAD_HIGH:
                begin
                    high_next[i] = pa[i];
                end
                default:
                begin
                end
            endcase
            ext[i] = {high_next[i][bba_pkg::COORD_W-1], high_next[i]}
                   - {low_next[i][bba_pkg::COORD_W-1], low_next[i]};
        end

        if (ext[0] <= ext[1])
            axis = (ext[2] <= ext[1]) ? bba_pkg::AXIS_Y : bba_pkg::AXIS_Z;
        else
            axis = (ext[2] <= ext[0]) ? bba_pkg::AXIS_X : bba_pkg::AXIS_Z;

        new_res.low_x        = low_next[0];
        new_res.low_y        = low_next[1];
        new_res.low_z        = low_next[2];
        new_res.high_x       = high_next[0];
        new_res.high_y       = high_next[1];
        new_res.high_z       = high_next[2];
        new_res.longest_axis = axis;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                low_reg[i]  <= bba_pkg::COORD_MAX;
                high_reg[i] <= bba_pkg::COORD_MIN;
            end
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (cmd_take)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    low_reg[i]  <= low_next[i];
                    high_reg[i] <= high_next[i];
                end
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, cmd_take} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            q_mem[wr_ptr_reg] <= new_res;
        end
    end

endmodule

@@ rtl/bounding_box_accumulator_unit.sv @@
// Top level of the bounding box accumulator: front decode queue feeding
// the box update back end. Depends on bba_pkg, bba_front, bba_back.
// A pushed beat is written into the front queue, then taken by the box
// update and written to the result queue, which shows it for popping.
// Throughput: one beat per cycle while the result queue is not full.
// Reset: asynchronous, active low; queues empty, box cleared to empty.
`timescale 1ns / 1ps

module bounding_box_accumulator_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           action,
    input  bba_pkg::coord_t      corner_a_x,
    input  bba_pkg::coord_t      corner_a_y,
    input  bba_pkg::coord_t      corner_a_z,
    input  bba_pkg::coord_t      corner_b_x,
    input  bba_pkg::coord_t      corner_b_y,
    input  bba_pkg::coord_t      corner_b_z,
    input  logic                 corner_a_finite,
    input  logic                 corner_b_finite,
    output logic                 empty,
    input  logic                 pop,
    output bba_pkg::coord_t      low_x,
    output bba_pkg::coord_t      low_y,
    output bba_pkg::coord_t      low_z,
    output bba_pkg::coord_t      high_x,
    output bba_pkg::coord_t      high_y,
    output bba_pkg::coord_t      high_z,
    output logic [1:0]           longest_axis
);

    logic             cmd_valid;
    logic             cmd_take;
    bba_pkg::cmd_t    cmd;
    bba_pkg::result_t res;

    bba_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .corner_a_x      (corner_a_x),
        .corner_a_y      (corner_a_y),
        .corner_a_z      (corner_a_z),
        .corner_b_x      (corner_b_x),
        .corner_b_y      (corner_b_y),
        .corner_b_z      (corner_b_z),
        .corner_a_finite (corner_a_finite),
        .corner_b_finite (corner_b_finite),
        .cmd_valid       (cmd_valid),
        .cmd_take        (cmd_take),
        .cmd             (cmd)
    );

    bba_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign low_x        = res.low_x;
    assign low_y        = res.low_y;
    assign low_z        = res.low_z;
    assign high_x       = res.high_x;
    assign high_y       = res.high_y;
    assign high_z       = res.high_z;
    assign longest_axis = res.longest_axis;

endmodule

@@ tb/bbox_check_pkg.sv @@
// Scoreboard for the bounding box accumulator testbench: keeps its own box
// and longest-axis prediction and checks each popped result in order.
// Depends on bba_pkg.
`timescale 1ns / 1ps

package bbox_check_pkg;

    import bba_pkg::*;

    typedef struct packed {
        logic [2:0] action;
        coord_t     ax;
        coord_t     ay;
        coord_t     az;
        coord_t     bx;
        coord_t     by;
        coord_t     bz;
        logic       fa;
        logic       fb;
    } box_beat_t;

    class bbox_scoreboard;

        coord_t  box_lo[3];
        coord_t  box_hi[3];
        result_t expected_boxes[$];
        int      mismatches;

        function new();
            empty_box();
            mismatches = 0;
        endfunction

        function void empty_box();
            for (int i = 0; i < 3; i++)
            begin
                box_lo[i] = COORD_MAX;
                box_hi[i] = COORD_MIN;
            end
        endfunction

        function void grow_box(coord_t x, coord_t y, coord_t z);
            coord_t p[3];
            p[0] = x;
            p[1] = y;
            p[2] = z;
            for (int i = 0; i < 3; i++)
            begin
                if (p[i] < box_lo[i])
                    box_lo[i] = p[i];
                if (p[i] > box_hi[i])
                    box_hi[i] = p[i];
            end
        endfunction

        // Extents are one bit wider than a coordinate and may be negative.
        function logic [1:0] longest_axis_of();
            extent_t ex;
            extent_t ey;
            extent_t ez;
            ex = extent_t'(box_hi[0]) - extent_t'(box_lo[0]);
            ey = extent_t'(box_hi[1]) - extent_t'(box_lo[1]);
            ez = extent_t'(box_hi[2]) - extent_t'(box_lo[2]);
            if (ex <= ey)
            begin
                if (ez <= ey)
                    return AXIS_Y;
            end
            else
            begin
                if (ez <= ex)
                    return AXIS_X;
            end
            return AXIS_Z;
        endfunction

        function void accept_command(box_beat_t c);
            result_t r;
            case (c.action)
                ACT_CLEAR:
                    empty_box();
                ACT_POINT:
                    grow_box(c.ax, c.ay, c.az);
                ACT_BOX:
                begin
                    if (c.fa)
                        grow_box(c.ax, c.ay, c.az);
                    if (c.fb)
                        grow_box(c.bx, c.by, c.bz);
                end
                ACT_LOAD_LOW:
                begin
                    box_lo[0] = c.ax;
                    box_lo[1] = c.ay;
                    box_lo[2] = c.az;
                end
                ACT_LOAD_HIGH:
                begin
                    box_hi[0] = c.ax;
                    box_hi[1] = c.ay;
                    box_hi[2] = c.az;
                end
                default:
                    ;
            endcase
            r.low_x        = box_lo[0];
            r.low_y        = box_lo[1];
            r.low_z        = box_lo[2];
            r.high_x       = box_hi[0];
            r.high_y       = box_hi[1];
            r.high_z       = box_hi[2];
            r.longest_axis = longest_axis_of();
            expected_boxes.push_back(r);
        endfunction

        function void check_box(result_t got);
            result_t exp;
            logic    bad;
            if (expected_boxes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat lo=(%h %h %h) hi=(%h %h %h) axis=%0d",
                             $time, got.low_x, got.low_y, got.low_z,
                             got.high_x, got.high_y, got.high_z, got.longest_axis);
                return;
            end
            exp = expected_boxes.pop_front();
            bad = (got.low_x !== exp.low_x) || (got.low_y !== exp.low_y)
                || (got.low_z !== exp.low_z) || (got.high_x !== exp.high_x)
                || (got.high_y !== exp.high_y) || (got.high_z !== exp.high_z)
                || (got.longest_axis !== exp.longest_axis);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: box mismatch", $time);
                    $display("  exp lo=(%h %h %h) hi=(%h %h %h) axis=%0d",
                             exp.low_x, exp.low_y, exp.low_z,
                             exp.high_x, exp.high_y, exp.high_z, exp.longest_axis);
                    $display("  got lo=(%h %h %h) hi=(%h %h %h) axis=%0d",
                             got.low_x, got.low_y, got.low_z,
                             got.high_x, got.high_y, got.high_z, got.longest_axis);
                end
            end
        endfunction

        function int pending();
            return expected_boxes.size();
        endfunction

    endclass

endpackage

@@ tb/tb_bounding_box_accumulator_unit.sv @@
// Testbench top for bounding_box_accumulator_unit: directed and random
// point, box, load and clear beats with bursty push and stalling pop.
// Depends on bba_pkg, bbox_check_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bounding_box_accumulator_unit;

    import bba_pkg::*;
    import bbox_check_pkg::*;

    localparam int RANDOM_BEATS = 750;
    localparam int CYCLE_LIMIT  = 400000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [2:0] action;
    coord_t     corner_a_x;
    coord_t     corner_a_y;
    coord_t     corner_a_z;
    coord_t     corner_b_x;
    coord_t     corner_b_y;
    coord_t     corner_b_z;
    logic       corner_a_finite;
    logic       corner_b_finite;
    logic       empty;
    logic       pop = 1'b0;
    coord_t     low_x;
    coord_t     low_y;
    coord_t     low_z;
    coord_t     high_x;
    coord_t     high_y;
    coord_t     high_z;
    logic [1:0] longest_axis;

    bbox_scoreboard sb = new();

    int unsigned cycles = 0;
    int          pop_mode = 0;
    int          pop_mode_left = 0;

    bounding_box_accumulator_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .corner_a_x      (corner_a_x),
        .corner_a_y      (corner_a_y),
        .corner_a_z      (corner_a_z),
        .corner_b_x      (corner_b_x),
        .corner_b_y      (corner_b_y),
        .corner_b_z      (corner_b_z),
        .corner_a_finite (corner_a_finite),
        .corner_b_finite (corner_b_finite),
        .empty           (empty),
        .pop             (pop),
        .low_x           (low_x),
        .low_y           (low_y),
        .low_z           (low_z),
        .high_x          (high_x),
        .high_y          (high_y),
        .high_z          (high_z),
        .longest_axis    (longest_axis)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: check the popped beat, then pick pop from the current stall mode.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_box('{low_x, low_y, low_z, high_x, high_y, high_z, longest_axis});
        if (pop_mode_left == 0)
        begin
            pop_mode      = $urandom_range(0, 3);
            pop_mode_left = (pop_mode == 3) ? $urandom_range(5, 30) : $urandom_range(20, 150);
        end
        else
            pop_mode_left = pop_mode_left - 1;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 1) == 1);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= 1'b0;
        endcase
    end

    function automatic box_beat_t mk(logic [2:0] act, coord_t ax, coord_t ay, coord_t az,
                                     coord_t bx, coord_t by, coord_t bz,
                                     logic fa, logic fb);
        box_beat_t c;
        c.action = act;
        c.ax = ax;
        c.ay = ay;
        c.az = az;
        c.bx = bx;
        c.by = by;
        c.bz = bz;
        c.fa = fa;
        c.fb = fb;
        return c;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3:    return coord_t'(int'($urandom_range(0, 16)) - 8);
            4:       return coord_t'((int'($urandom_range(0, 200)) - 100) * 65536);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic box_beat_t rand_beat();
        int         r;
        logic [2:0] act;
        r = $urandom_range(0, 99);
        if (r < 6)
            act = ACT_CLEAR;
        else if (r < 40)
            act = ACT_POINT;
        else if (r < 75)
            act = ACT_BOX;
        else if (r < 83)
            act = ACT_LOAD_LOW;
        else if (r < 91)
            act = ACT_LOAD_HIGH;
        else
            act = 3'($urandom_range(5, 7));
        return mk(act, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_beat(input box_beat_t c);
        push            <= 1'b1;
        action          <= c.action;
        corner_a_x      <= c.ax;
        corner_a_y      <= c.ay;
        corner_a_z      <= c.az;
        corner_b_x      <= c.bx;
        corner_b_y      <= c.by;
        corner_b_z      <= c.bz;
        corner_a_finite <= c.fa;
        corner_b_finite <= c.fb;
        do
            @(posedge clk);
        while (full);
        sb.accept_command(c);
    endtask

    task automatic idle_cycles(input int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        box_beat_t d[$];
        int        sent;
        int        burst;
        bit        mid_drained;

        rst_n           = 1'b0;
        push            = 1'b0;
        action          = ACT_CLEAR;
        corner_a_x      = '0;
        corner_a_y      = '0;
        corner_a_z      = '0;
        corner_b_x      = '0;
        corner_b_y      = '0;
        corner_b_z      = '0;
        corner_a_finite = 1'b0;
        corner_b_finite = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unused action right after reset shows the empty box
        d.push_back(mk(3'd5, 1, 2, 3, 4, 5, 6, 1'b1, 1'b1));
        d.push_back(mk(ACT_POINT, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0));
        d.push_back(mk(ACT_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 1'b1, 1'b1));
        d.push_back(mk(ACT_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 1'b0, 1'b1));
        d.push_back(mk(ACT_CLEAR, 7, 7, 7, 7, 7, 7, 1'b1, 1'b1));
        d.push_back(mk(ACT_BOX, 1, 2, 3, 4, 5, 6, 1'b0, 1'b0));
        d.push_back(mk(ACT_BOX, 65536, -65536, 3, 100, 200, 300, 1'b1, 1'b0));
        d.push_back(mk(ACT_BOX, 0, 0, 0, -500, 400, -7, 1'b0, 1'b1));
        d.push_back(mk(ACT_BOX, 9000, -9000, 50, -9000, 9000, -50, 1'b1, 1'b1));
        // tie cases on the longest axis
        d.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(ACT_POINT, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(ACT_POINT, 5, 5, 0, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(ACT_BOX, 0, 0, 0, 5, 0, 5, 1'b1, 1'b1));
        d.push_back(mk(ACT_POINT, 0, 0, 9, 0, 0, 0, 1'b0, 1'b0));
        // loads with low above high give negative extents
        d.push_back(mk(ACT_LOAD_LOW, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 1'b1, 1'b1));
        d.push_back(mk(ACT_LOAD_HIGH, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(ACT_LOAD_HIGH, 10, 20, 30, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(ACT_LOAD_LOW, 40, 20, 50, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(ACT_LOAD_LOW, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(ACT_LOAD_HIGH, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 1'b0, 1'b0));
        d.push_back(mk(3'd6, 1, 1, 1, 1, 1, 1, 1'b1, 1'b1));
        d.push_back(mk(3'd7, -1, -1, -1, -1, -1, -1, 1'b0, 1'b1));
        d.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        foreach (d[i])
        begin
            send_beat(d[i]);
            if (i % 5 == 4)
                idle_cycles($urandom_range(1, 4));
        end
        wait_drained();

        sent        = 0;
        mid_drained = 1'b0;
        while (sent < RANDOM_BEATS)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < RANDOM_BEATS; k++)
            begin
                send_beat(rand_beat());
                sent++;
            end
            if (!mid_drained && sent >= RANDOM_BEATS / 2)
            begin
                wait_drained();
                mid_drained = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 12));
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
